>>> rtl/assert_macros.svh
// assertion macros shared by the cache rtl
// every macro samples on clock and is disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/lkvc_pkg.sv
// shared types and constants of the lru key-value cache
// used by the controller, datapath and top level; depends on nothing
`default_nettype none

package lkvc_pkg;

   // storage geometry
   localparam int ENTRIES     = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_WIDTH   = $clog2(ENTRIES);
   localparam int RANK_WIDTH  = $clog2(ENTRIES);
   localparam int COUNT_WIDTH = $clog2(ENTRIES + 1);

   // capacity register
   localparam int CAP_WIDTH = 5;
   localparam int CMP_WIDTH = (CAP_WIDTH > COUNT_WIDTH) ? CAP_WIDTH : COUNT_WIDTH;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(ENTRIES);

   // csr port
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_CAPACITY = '0;

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } lkvc_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;  // word accepted: register the match results
      logic commit;   // update the store and load the result word
   } lkvc_cmd_type;

endpackage

`default_nettype wire

>>> rtl/lkvc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// self-contained, no package dependency
`default_nettype none

module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/lkvc_ctrl.sv
// controller of the lru key-value cache: match/update sequencing and result handshake
// depends on lkvc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lkvc_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output lkvc_pkg::lkvc_cmd_type cmd
);

   lkvc_pkg::lkvc_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // result register can take a new word
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req_valid) state_in = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            if (out_free) state_in = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = 1'b1;
      cmd         = '0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         lkvc_pkg::ST_UPDATE: begin
            cmd.commit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // result valid flag
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a result word appears only after a commit
   `ASSERT_ALWAYS(a_valid_after_commit, $rose(rsp_valid_ff) |-> $past(cmd.commit), "result word without commit")
   // a commit always loads the result word
   `ASSERT_NEXT(a_commit_loads_word, cmd.commit, rsp_valid_ff, "commit did not load result word")

endmodule

`default_nettype wire

>>> rtl/lkvc_datapath.sv
// datapath of the lru key-value cache: key match, recency ranks, value ram, result word
// depends on lkvc_pkg, lkvc_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lkvc_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lkvc_pkg::lkvc_cmd_type               cmd,
   input  wire logic [lkvc_pkg::CAP_WIDTH-1:0]       capacity,
   input  wire logic                                 req_operation,
   input  wire logic [lkvc_pkg::KEY_WIDTH-1:0]       req_key,
   input  wire logic [lkvc_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                      rsp_hit,
   output logic      [lkvc_pkg::VALUE_WIDTH-1:0]     rsp_read_value
);

   localparam int N  = lkvc_pkg::ENTRIES;
   localparam int IW = lkvc_pkg::IDX_WIDTH;
   localparam int RW = lkvc_pkg::RANK_WIDTH;
   localparam int CW = lkvc_pkg::COUNT_WIDTH;
   localparam int MW = lkvc_pkg::CMP_WIDTH;

   // per-slot state
   logic [N-1:0]                       valid_ff, valid_in;
   logic [lkvc_pkg::KEY_WIDTH-1:0]     key_ff [N];
   logic [lkvc_pkg::KEY_WIDTH-1:0]     key_in [N];
   logic [RW-1:0]                      rank_ff [N];
   logic [RW-1:0]                      rank_in [N];
   logic [CW-1:0]                      used_ff, used_in;

   // captured word and match results
   logic                               op_ff;
   logic [lkvc_pkg::KEY_WIDTH-1:0]     cur_key_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   cur_value_ff;
   logic                               hit_ff, hit_in;
   logic [IW-1:0]                      slot_ff, slot_in;
   logic                               touch_ff, touch_in;
   logic                               fill_ff, fill_in;
   logic                               newkey_ff, newkey_in;
   logic [RW-1:0]                      age_ff, age_in;

   // result word
   logic                               rsp_hit_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   rsp_read_value_ff, rsp_read_value_in;

   // match logic
   logic [N-1:0]      match_vec, free_vec, oldest_vec;
   logic [IW-1:0]     found_idx, free_idx, oldest_idx;
   logic              found_any, free_any, full;
   logic [MW-1:0]     cap_eff;
   logic [CW-1:0]     used_minus_one;

   // ram
   logic [IW-1:0]                      rd_addr;
   logic                               ram_wr_en;
   logic [lkvc_pkg::VALUE_WIDTH-1:0]   ram_rd_data;

   assign used_minus_one = used_ff - CW'(1);

   // parallel key compare, free and oldest slot flags
   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_vec[i]  = valid_ff[i] && (key_ff[i] == req_key);
         free_vec[i]   = !valid_ff[i];
         oldest_vec[i] = valid_ff[i] && (CW'(rank_ff[i]) == used_minus_one);
      end
   end

   // lowest-numbered slot of each kind
   always_comb begin
      found_idx  = '0;
      free_idx   = '0;
      oldest_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match_vec[i])  found_idx  = IW'(i);
         if (free_vec[i])   free_idx   = IW'(i);
         if (oldest_vec[i]) oldest_idx = IW'(i);
      end
   end

   assign found_any = |match_vec;
   assign free_any  = |free_vec;

   // effective capacity, clamped to one..entries
   always_comb begin
      cap_eff = MW'(capacity);
      if (capacity == '0) begin
         cap_eff = MW'(1);
      end else if (MW'(capacity) > MW'(N)) begin
         cap_eff = MW'(N);
      end
   end

   assign full = (MW'(used_ff) >= cap_eff) || !free_any;

   // choose the slot to touch for this word
   always_comb begin
      hit_in    = found_any;
      slot_in   = found_idx;
      touch_in  = 1'b0;
      fill_in   = 1'b0;
      newkey_in = 1'b0;
      age_in    = rank_ff[found_idx];
      if (found_any) begin
         touch_in = 1'b1;
      end else if (req_operation == lkvc_pkg::OP_PUT) begin
         touch_in  = 1'b1;
         newkey_in = 1'b1;
         if (full) begin
            slot_in = oldest_idx;
            age_in  = rank_ff[oldest_idx];
         end else begin
            slot_in = free_idx;
            fill_in = 1'b1;
            age_in  = RW'(used_ff);
         end
      end
   end

   // capture on accept
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_operation;
         cur_key_ff   <= req_key;
         cur_value_ff <= req_value;
         hit_ff       <= hit_in;
         slot_ff      <= slot_in;
         touch_ff     <= touch_in;
         fill_ff      <= fill_in;
         newkey_ff    <= newkey_in;
         age_ff       <= age_in;
      end
   end

   // value store, read at the matching slot while the word is accepted
   assign rd_addr   = cmd.capture ? found_idx : slot_ff;
   assign ram_wr_en = cmd.commit && (op_ff == lkvc_pkg::OP_PUT);

   lkvc_ram #(
      .WIDTH (lkvc_pkg::VALUE_WIDTH),
      .DEPTH (lkvc_pkg::ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (cur_value_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // recency, valid, key and count updates
   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      for (int i = 0; i < N; i++) begin
         key_in[i]  = key_ff[i];
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit && touch_ff) begin
         for (int i = 0; i < N; i++) begin
            if (IW'(i) == slot_ff) begin
               rank_in[i] = '0;
               if (newkey_ff) key_in[i] = cur_key_ff;
            end else if (valid_ff[i] && (rank_ff[i] < age_ff)) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
         if (fill_ff) begin
            valid_in[slot_ff] = 1'b1;
            used_in           = used_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         key_ff[i] <= key_in[i];
      end
   end

   // result word, value only on a get hit
   assign rsp_read_value_in = (hit_ff && (op_ff == lkvc_pkg::OP_GET)) ? ram_rd_data : '0;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff        <= hit_ff;
         rsp_read_value_ff <= rsp_read_value_in;
      end
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

   // fill count tracks the valid bits
   `ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_ff) == used_ff, "fill count out of step")
   // a fill goes only into a free slot
   `ASSERT_ALWAYS(a_fill_free_slot, (cmd.commit && fill_ff) |-> !valid_ff[slot_ff], "fill into used slot")
   // a hit always names a live slot
   `ASSERT_ALWAYS(a_hit_slot_valid, (cmd.commit && hit_ff) |-> valid_ff[slot_ff], "hit on invalid slot")

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache_top.sv
// lru key-value cache, 16 fully associative entries with least-recent replacement
// result word loaded by the commit in the update state after a request word is accepted
// one word at a time: key match on accept, then value ram read and rank update
// a stalled result word holds the next word in its update cycle; requests stall meanwhile
// reset (synchronous): all entries invalid, ranks and fill count zero, capacity 16
// no clearing pass; keys and values need no reset
`default_nettype none

module lru_key_value_cache_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_operation,
   input  wire logic [lkvc_pkg::KEY_WIDTH-1:0]         req_key,
   input  wire logic [lkvc_pkg::VALUE_WIDTH-1:0]       req_value,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_hit,
   output logic      [lkvc_pkg::VALUE_WIDTH-1:0]       rsp_read_value,
   // csr port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [lkvc_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [lkvc_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic      [lkvc_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                        csr_pready
);

   lkvc_pkg::lkvc_cmd_type cmd;

   logic [lkvc_pkg::CAP_WIDTH-1:0]       capacity_ff, capacity_in;
   logic [lkvc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic                                 csr_wr;

   // capacity register
   assign csr_index = csr_paddr[lkvc_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && (csr_index == lkvc_pkg::CSR_IDX_CAPACITY)) begin
         capacity_in = csr_pwdata[lkvc_pkg::CAP_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign csr_prdata = (csr_index == lkvc_pkg::CSR_IDX_CAPACITY) ?
                       lkvc_pkg::CSR_DATA_WIDTH'(capacity_ff) : '0;

   // sequencing
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // storage and match
   lkvc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .capacity       (capacity_ff),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value)
   );

endmodule

`default_nettype wire
